FILE: hdl/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared types and constants for the sorted set table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssu_pkg;

  // field widths fixed by the interface
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int CNT_W        = 7;

  // default number of slots
  localparam int CAPACITY_DEF = 64;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_DECIDE,
    ST_COMMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic compare;  // every slot compares itself against the value
    logic decide;   // reduce match flags, pick the action
    logic commit;   // shift the row, update count, present result
  } ssu_cmd_t;

endpackage : ssu_pkg

`default_nettype wire

FILE: hdl/sorted_set_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_table_unit
// Ordered set of distinct signed words with insert, erase, find and clear.
// ----------------------------------------------------------------------------
//  channel   signals                 dir   notes
//  command   start, mode, value      in    taken when start high, busy low
//  result    done, present, count,   out   one-cycle beat, no back-pressure
//            full_drop
//
//  each operation passes from acceptance to its result beat through a compare
//  in every slot, match reduction, then shift and count update; busy is high
//  from the compare step through the commit step, and a new beat can be taken
//  in the same cycle as the previous result beat
//  reset clears the count and the sequencer; slot contents need no clearing
//  results cannot be stalled, so no skid storage is present
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_table_unit
  import ssu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      done,
  output logic                      present,
  output logic [CNT_W-1:0]          count,
  output logic                      full_drop
);

  ssu_cmd_t cmd;

  // sequencer
  ssu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // slot row and result registers
  ssu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mode      (mode),
    .value     (value),
    .done      (done),
    .present   (present),
    .count     (count),
    .full_drop (full_drop)
  );

  // result beat always closes a busy period
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a preceding operation");

  // a refused insert never reports a present value
  a_drop_excl : assert property (@(posedge clk) disable iff (rst)
    done |-> !(present && full_drop))
    else $error("present and full_drop both set");

  // count stays within capacity while it fits the field
  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    done |-> ((CAPACITY > 127) || (int'(count) <= CAPACITY)))
    else $error("count above capacity");

  // busy only rises on an accepted command
  a_busy_start : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule : sorted_set_table_unit

`default_nettype wire

FILE: hdl/ssu_ctrl.sv
// ----------------------------------------------------------------------------
// ssu_ctrl
// Sequencer: steps each accepted operation through compare, decide, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssu_ctrl
  import ssu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output ssu_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_DECIDE;
      ST_DECIDE:  state_next = ST_COMMIT;
      ST_COMMIT:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_COMPARE: cmd.compare = 1'b1;
      ST_DECIDE:  cmd.decide  = 1'b1;
      ST_COMMIT:  cmd.commit  = 1'b1;
      default:    busy = 1'b0;
    endcase
  end

endmodule : ssu_ctrl

`default_nettype wire

FILE: hdl/ssu_datapath.sv
// ----------------------------------------------------------------------------
// ssu_datapath
// Row of sorted slots with a comparator per slot, match reduction and the
// shift network for insert and erase.
// ----------------------------------------------------------------------------
`default_nettype none

module ssu_datapath
  import ssu_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  ssu_cmd_t                  cmd,
  input  logic [MODE_W-1:0]         mode,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      done,
  output logic                      present,
  output logic [CNT_W-1:0]          count,
  output logic                      full_drop
);

  localparam int HW = $clog2(CAPACITY + 1);

  // captured beat
  mode_t                      mode_q;
  logic signed [VALUE_W-1:0]  value_q;

  // slot row and element count
  logic signed [VALUE_W-1:0]  entries [CAPACITY];
  logic [HW-1:0]              held;
  logic [HW-1:0]              held_next;

  // per-slot compare flags, valid slots only
  logic [CAPACITY-1:0]        lt_vec;
  logic [CAPACITY-1:0]        eq_vec;

  // decision registers
  logic                       hit;
  logic                       do_insert;
  logic                       do_erase;
  logic                       do_clear;
  logic                       drop;

  // capture the beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode_t'(mode);
      value_q <= value;
    end
  end

  // per-slot comparators and shift network
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic valid;
    logic prev_lt;
    logic signed [VALUE_W-1:0] from_below;
    logic signed [VALUE_W-1:0] from_above;

    assign valid = HW'(i) < held;

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b0;
      assign from_below = value_q;
    end else begin : g_rest
      assign prev_lt    = lt_vec[i-1];
      assign from_below = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign from_above = entries[i];
    end else begin : g_inner
      assign from_above = entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        lt_vec[i] <= valid && (entries[i] < value_q);
        eq_vec[i] <= valid && (entries[i] == value_q);
      end
    end

    // slots at or above the insert point move up, the gap takes the value; on erase they move down
    always_ff @(posedge clk) begin
      if (cmd.commit && do_insert && !lt_vec[i]) begin
        entries[i] <= (i == 0 || prev_lt) ? value_q : from_below;
      end else if (cmd.commit && do_erase && !lt_vec[i]) begin
        entries[i] <= from_above;
      end
    end
  end

  // reduce matches and choose the action
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hit       <= |eq_vec;
      do_insert <= 1'b0;
      do_erase  <= 1'b0;
      do_clear  <= 1'b0;
      drop      <= 1'b0;
      case (mode_q)
        MODE_INSERT: begin
          if (!(|eq_vec)) begin
            if (held >= HW'(CAPACITY)) begin
              drop <= 1'b1;
            end else begin
              do_insert <= 1'b1;
            end
          end
        end
        MODE_ERASE: do_erase <= |eq_vec;
        MODE_FIND:  ;
        MODE_CLEAR: begin
          do_clear <= 1'b1;
          hit      <= 1'b0;
        end
        default:    ;
      endcase
    end
  end

  // count after this operation
  always_comb begin
    held_next = held;
    if (do_clear) begin
      held_next = '0;
    end else if (do_insert) begin
      held_next = held + HW'(1);
    end else if (do_erase) begin
      held_next = held - HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.commit) begin
      held <= held_next;
    end
  end

  // result beat, one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      present   <= hit;
      count     <= CNT_W'(held_next);
      full_drop <= drop;
    end
  end

endmodule : ssu_datapath

`default_nettype wire
